>>> hdl/c_escape_sequence_decoder_macros.svh
// ----------------------------------------------------------------------------
// Escape decoder assertion macros
// Clocked concurrent assertion helpers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define C_ESCAPE_SEQUENCE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every edge out of reset
`define CED_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("escape decoder check failed");
// condition must never be true out of reset
`define CED_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("escape decoder forbidden condition");
`else
`define CED_ASSERT(label, clk, rst_n, prop)
`define CED_NEVER(label, clk, rst_n, cond)
`endif

`endif

>>> hdl/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg
// Types, character codes and lookup functions of the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ced_pkg;

  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_X      = 16'h0078;

  typedef enum logic [4:0] {
    MODE_TEXT      = 5'b00001,
    MODE_ESC       = 5'b00010,
    MODE_HEX_FIRST = 5'b00100,
    MODE_HEX       = 5'b01000,
    MODE_OCT       = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [15:0] decoded_unit;
    logic        has_unit;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t        res0;
    res_t        res1;
    logic [1:0]  cnt;
    mode_t       mode;
    logic [15:0] acc;
  } dec_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] val;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // simple escapes: a b f n r t v " ? ' backslash
  function automatic esc_t esc_lookup(logic [15:0] cu);
    esc_t e;
    e.hit = 1'b1;
    e.val = 16'h0000;
    case (cu)
      16'h0061: e.val = 16'h0007;
      16'h0062: e.val = 16'h0008;
      16'h0066: e.val = 16'h000C;
      16'h006E: e.val = 16'h000A;
      16'h0072: e.val = 16'h000D;
      16'h0074: e.val = 16'h0009;
      16'h0076: e.val = 16'h000B;
      16'h0022, 16'h003F, 16'h0027, 16'h005C: e.val = cu;
      default:  e.hit = 1'b0;
    endcase
    return e;
  endfunction

  function automatic hex_t hex_digit(logic [15:0] cu);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'h0;
    if (cu >= 16'h0030 && cu <= 16'h0039) begin
      h.val = cu[3:0];
    end else if ((cu >= 16'h0041 && cu <= 16'h0046) ||
                 (cu >= 16'h0061 && cu <= 16'h0066)) begin
      h.val = cu[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_oct(logic [15:0] cu);
    return cu[15:3] == 13'h0006;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ced_in_if.sv
// ----------------------------------------------------------------------------
// ced_in_if
// Input channel of the escape decoder: one code unit per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ced_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_string;

  modport source (output valid, output code_unit, output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

`default_nettype wire

>>> hdl/ced_out_if.sv
// ----------------------------------------------------------------------------
// ced_out_if
// Result channel of the escape decoder: at most one decoded unit per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ced_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] decoded_unit;
  logic        has_unit;
  logic        last;

  modport source (output valid, output decoded_unit, output has_unit, output last,
                  input ready);
  modport sink   (input valid, input decoded_unit, input has_unit, input last,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/ced_decode.sv
// ----------------------------------------------------------------------------
// ced_decode
// Per-unit decode: next mode, next accumulator and up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module ced_decode import ced_pkg::*; (
  input  mode_t       mode,
  input  logic [15:0] acc,
  input  logic [15:0] code_unit,
  input  logic        end_of_string,
  output dec_t        dec
);

  function automatic dec_t add_unit(dec_t d, logic [15:0] v, logic has);
    dec_t r;
    r = d;
    if (d.cnt == 2'd0) begin
      r.res0 = '{decoded_unit: v, has_unit: has, last: 1'b0};
    end else begin
      r.res1 = '{decoded_unit: v, has_unit: has, last: 1'b0};
    end
    r.cnt = d.cnt + 2'd1;
    return r;
  endfunction

  function automatic dec_t plain(dec_t d, logic [15:0] cu);
    dec_t r;
    r = d;
    if (cu == CH_BSLASH) begin
      r.mode = MODE_ESC;
    end else begin
      r = add_unit(d, cu, 1'b1);
    end
    return r;
  endfunction

  esc_t esc;
  hex_t hx;
  logic oct;

  assign esc = esc_lookup(code_unit);
  assign hx  = hex_digit(code_unit);
  assign oct = is_oct(code_unit);

  always_comb begin
    dec      = '0;
    dec.mode = MODE_TEXT;
    dec.acc  = acc;
    unique case (mode)
      MODE_ESC: begin
        if (esc.hit) begin
          dec = add_unit(dec, esc.val, 1'b1);
        end else if (code_unit == CH_X) begin
          dec.acc  = 16'h0000;
          dec.mode = MODE_HEX_FIRST;
        end else if (oct) begin
          dec.acc  = {13'h0000, code_unit[2:0]};
          dec.mode = MODE_OCT;
        end
      end
      MODE_HEX_FIRST: begin
        if (hx.ok) begin
          dec.acc  = {12'h000, hx.val};
          dec.mode = MODE_HEX;
        end else begin
          dec = plain(dec, code_unit);
        end
      end
      MODE_HEX: begin
        if (hx.ok) begin
          dec.acc  = {acc[11:0], 4'h0} + {12'h000, hx.val};
          dec.mode = MODE_HEX;
        end else begin
          dec = add_unit(dec, acc, 1'b1);
          dec = plain(dec, code_unit);
        end
      end
      MODE_OCT: begin
        if (oct) begin
          dec.acc  = {acc[12:0], 3'b000} + {13'h0000, code_unit[2:0]};
          dec.mode = MODE_OCT;
        end else begin
          dec = add_unit(dec, acc, 1'b1);
          dec = plain(dec, code_unit);
        end
      end
      default: begin
        dec = plain(dec, code_unit);
      end
    endcase

    // end of string: flush a pending value, add an empty result if there is none, mark the final result
    if (end_of_string) begin
      if (dec.mode == MODE_HEX || dec.mode == MODE_OCT) begin
        dec = add_unit(dec, dec.acc, 1'b1);
      end
      if (dec.cnt == 2'd0) begin
        dec = add_unit(dec, 16'h0000, 1'b0);
      end
      if (dec.cnt == 2'd1) begin
        dec.res0.last = 1'b1;
      end else begin
        dec.res1.last = 1'b1;
      end
      dec.mode = MODE_TEXT;
      dec.acc  = 16'h0000;
    end
  end

endmodule

`default_nettype wire

>>> hdl/c_escape_sequence_decoder.sv
// Results: the first result of a unit is offered in the cycle after the unit is accepted.
// Throughput: one unit per cycle while the result side is ready; a unit giving two
//   results (a value flushed plus a character) holds the input while the
//   two-entry result buffer drains.
// Reset: synchronous, active low; returns to text mode, clears the
//   accumulator and empties the result buffer.
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// Decodes C-style escapes in a stream of 16-bit code units.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_escape_sequence_decoder_macros.svh"

module c_escape_sequence_decoder import ced_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ced_in_if.sink     in_if,
  ced_out_if.source  out_if
);

  mode_t       mode_r;
  logic [15:0] acc_r;
  res_t        slot_r [2];
  res_t        slot_nxt [2];
  logic [1:0]  cnt_r, cnt_nxt;
  dec_t        dec;
  logic        push, pop;

  ced_decode u_decode (
    .mode          (mode_r),
    .acc           (acc_r),
    .code_unit     (in_if.code_unit),
    .end_of_string (in_if.end_of_string),
    .dec           (dec)
  );

  // accept only when the buffer is empty after this cycle
  assign in_if.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_if.ready);
  assign push        = in_if.valid && in_if.ready;
  assign pop         = out_if.valid && out_if.ready;

  assign out_if.valid        = cnt_r != 2'd0;
  assign out_if.decoded_unit = slot_r[0].decoded_unit;
  assign out_if.has_unit     = slot_r[0].has_unit;
  assign out_if.last         = slot_r[0].last;

  always_comb begin
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    cnt_nxt     = cnt_r;
    if (push) begin
      slot_nxt[0] = dec.res0;
      slot_nxt[1] = dec.res1;
      cnt_nxt     = dec.cnt;
    end else if (pop) begin
      slot_nxt[0] = slot_r[1];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      acc_r  <= 16'h0000;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        mode_r <= dec.mode;
        acc_r  <= dec.acc;
      end
    end
  end

  `CED_NEVER(a_cnt_range, clk, rst_n, cnt_r == 2'd3)
  `CED_NEVER(a_full_no_accept, clk, rst_n, cnt_r == 2'd2 && in_if.ready)
  `CED_NEVER(a_last_at_tail, clk, rst_n, cnt_r == 2'd2 && slot_r[0].last)
  `CED_ASSERT(a_end_resets, clk, rst_n,
    push && in_if.end_of_string |=> mode_r == MODE_TEXT && acc_r == 16'h0000)

endmodule

`default_nettype wire

>>> test/ced_decode_checker.sv
// ----------------------------------------------------------------------------
// ced_decode_checker
// Watches both channels of the escape decoder. Each accepted code unit runs
// through a cycle-free decode model. Each accepted result is matched field
// by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module ced_decode_checker import ced_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ced_in_if    in_mon,
  ced_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  mode_t       dmode;
  logic [15:0] acc;
  res_t        decoded_q[$];
  res_t        step_res[2];
  int          step_n;
  int          errs;

  // -1 when the unit is not a hex digit
  function automatic int hex_val(logic [15:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  task automatic add_unit(input logic [15:0] v, input logic has);
    if (step_n < 2) begin
      step_res[step_n] = '{decoded_unit: v, has_unit: has, last: 1'b0};
    end else begin
      $error("more than two results predicted for one item");
      errs++;
    end
    step_n++;
  endtask

  task automatic take_text(input logic [15:0] c);
    dmode = MODE_TEXT;
    if (c == CH_BSLASH) begin
      dmode = MODE_ESC;
    end else begin
      add_unit(c, 1'b1);
    end
  endtask

  task automatic decode_unit(input logic [15:0] cu, input logic eos);
    int d;
    step_n = 0;
    d = hex_val(cu);
    case (dmode)
      MODE_ESC: begin
        dmode = MODE_TEXT;
        case (cu)
          "a": add_unit(16'h0007, 1'b1);
          "b": add_unit(16'h0008, 1'b1);
          "f": add_unit(16'h000C, 1'b1);
          "n": add_unit(16'h000A, 1'b1);
          "r": add_unit(16'h000D, 1'b1);
          "t": add_unit(16'h0009, 1'b1);
          "v": add_unit(16'h000B, 1'b1);
          "\"", "?", "'", "\\": add_unit(cu, 1'b1);
          CH_X: begin
            acc   = '0;
            dmode = MODE_HEX_FIRST;
          end
          default: begin
            // octal start; anything else drops both units
            if (cu >= "0" && cu <= "7") begin
              acc   = {13'd0, cu[2:0]};
              dmode = MODE_OCT;
            end
          end
        endcase
      end
      MODE_HEX_FIRST: begin
        if (d >= 0) begin
          acc   = {12'd0, d[3:0]};
          dmode = MODE_HEX;
        end else begin
          take_text(cu);
        end
      end
      MODE_HEX: begin
        if (d >= 0) begin
          acc = {acc[11:0], d[3:0]};
        end else begin
          add_unit(acc, 1'b1);
          take_text(cu);
        end
      end
      MODE_OCT: begin
        if (cu >= "0" && cu <= "7") begin
          acc = {acc[12:0], cu[2:0]};
        end else begin
          add_unit(acc, 1'b1);
          take_text(cu);
        end
      end
      default: take_text(cu);
    endcase

    if (eos) begin
      if (dmode == MODE_HEX || dmode == MODE_OCT) add_unit(acc, 1'b1);
      if (step_n == 0) add_unit(16'h0000, 1'b0);
      if (step_n <= 2) step_res[step_n-1].last = 1'b1;
      dmode = MODE_TEXT;
      acc   = '0;
    end

    for (int i = 0; i < step_n && i < 2; i++) decoded_q.push_back(step_res[i]);
  endtask

  task automatic check_result();
    res_t e;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: decoded_unit %h has_unit %b last %b",
             out_mon.decoded_unit, out_mon.has_unit, out_mon.last);
      errs++;
    end else begin
      e = decoded_q.pop_front();
      if (out_mon.decoded_unit !== e.decoded_unit) begin
        $error("decoded_unit: expected %h, got %h", e.decoded_unit, out_mon.decoded_unit);
        errs++;
      end
      if (out_mon.has_unit !== e.has_unit) begin
        $error("has_unit: expected %b, got %b", e.has_unit, out_mon.has_unit);
        errs++;
      end
      if (out_mon.last !== e.last) begin
        $error("last: expected %b, got %b", e.last, out_mon.last);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dmode = MODE_TEXT;
      acc   = '0;
      decoded_q.delete();
      errs  = 0;
    end else begin
      // a result never belongs to the unit accepted at the same edge
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) decode_unit(in_mon.code_unit, in_mon.end_of_string);
    end
    pending    <= decoded_q.size();
    fail_count <= errs;
  end

endmodule

>>> test/tb_c_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// tb_c_escape_sequence_decoder
// Drives escaped strings into the decoder: a directed set of corner cases,
// then random strings of escape tokens and noise, with random gaps on both
// channels. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_c_escape_sequence_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int UNIT_TARGET = 440;
  localparam logic [15:0] CH_BSLASH_T = ced_pkg::CH_BSLASH;

  logic clk;
  logic rst_n;
  int   cycles;
  int   sent;
  bit   calm;
  int   fail_count;
  int   pending;

  ced_in_if  in_if();
  ced_out_if out_if();

  c_escape_sequence_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  ced_decode_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 16'("0") + 16'(v);
    return ($urandom_range(0, 1) ? 16'("A") : 16'("a")) + 16'(v - 10);
  endfunction

  // valid stays high across back-to-back items; lowered only for a gap or a drain
  task automatic send_unit(input logic [15:0] cu, input logic eos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.code_unit     <= cu;
    in_if.end_of_string <= eos;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic send_text(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++)
      send_unit({8'h00, s[i]}, eos_last && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side: random stall before each item
  initial begin
    int stall;
    out_if.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  initial begin
    logic [15:0] esc_keys[11];
    logic [15:0] str[$];
    int          n_strings;
    int          ntok;
    int          nd;
    esc_keys = '{"a", "b", "f", "n", "r", "t", "v", "\"", "?", "'", "\\"};
    cycles              = 0;
    sent                = 0;
    calm                = 1'b0;
    n_strings           = 0;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.code_unit     = '0;
    in_if.end_of_string = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0000, 1'b1);
    send_text("\\n\\xFfG", 1'b0);   // hex ended by a plain unit
    send_text("\\778", 1'b0);       // octal ended by a non-octal digit
    send_text("\\xz\\q", 1'b0);     // x without digit, then unknown escape
    send_text("\\", 1'b1);          // trailing backslash: empty end
    send_text("\\x", 1'b1);         // trailing x: empty end
    send_text("\\x12345", 1'b1);    // wraps, flushed by the end flag

    while (sent < UNIT_TARGET) begin
      str.delete();
      calm = ($urandom_range(0, 4) == 0);
      if (n_strings == 25) wait_drained();
      if ($urandom_range(0, 9) < 8) begin
        ntok = $urandom_range(1, 6);
        repeat (ntok) begin
          case ($urandom_range(0, 6))
            0: str.push_back(16'($urandom_range(32, 126)));
            1: str.push_back(16'($urandom));
            2: begin
              str.push_back(CH_BSLASH_T);
              str.push_back(esc_keys[$urandom_range(0, 10)]);
            end
            3: begin
              str.push_back(CH_BSLASH_T);
              str.push_back(16'("x"));
              nd = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
              repeat (nd) str.push_back(hex_char());
            end
            4: begin
              str.push_back(CH_BSLASH_T);
              nd = $urandom_range(1, 7);
              repeat (nd) str.push_back(16'("0") + 16'($urandom_range(0, 7)));
            end
            5: begin
              str.push_back(CH_BSLASH_T);
              str.push_back(16'($urandom_range(32, 126)));
            end
            default: str.push_back(CH_BSLASH_T);
          endcase
        end
      end else begin
        // noise: raw units mixed with escape-looking ones
        ntok = $urandom_range(1, 8);
        repeat (ntok) begin
          case ($urandom_range(0, 4))
            0: str.push_back(CH_BSLASH_T);
            1: str.push_back(16'("x"));
            2: str.push_back(16'("0") + 16'($urandom_range(0, 9)));
            default: str.push_back(16'($urandom));
          endcase
        end
      end
      foreach (str[i]) send_unit(str[i], i == str.size() - 1);
      n_strings++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
